@@ rtl/core/serp_pkg.sv @@
// Shared types, tables and round functions for the Serpent cipher core.
package serp_pkg;

	localparam int WORD_W    = 32;
	localparam int KEY_WORDS = 8;
	localparam int KEY_REGS  = 4;
	localparam int RK_WORDS  = 132;
	localparam int RK_GROUPS = 33;
	localparam int ROUNDS    = 32;
	localparam int CFG_IDX_W = 3;
	localparam int RK_IDX_W  = 6;
	localparam int CNT_W     = 8;
	localparam logic [WORD_W-1:0] GOLDEN = 32'h9E3779B9;

	localparam logic CMD_ENC = 1'b0;
	localparam logic CMD_DEC = 1'b1;

	// x[0] .. x[3] of one 128-bit block
	typedef logic [3:0][WORD_W-1:0] blk_t;
	typedef logic [WORD_W-1:0] word_t;

	localparam logic [3:0] SBOX [8][16] = '{
		'{4'd3, 4'd8, 4'd15, 4'd1, 4'd10, 4'd6, 4'd5, 4'd11,
		  4'd14, 4'd13, 4'd4, 4'd2, 4'd7, 4'd0, 4'd9, 4'd12},
		'{4'd15, 4'd12, 4'd2, 4'd7, 4'd9, 4'd0, 4'd5, 4'd10,
		  4'd1, 4'd11, 4'd14, 4'd8, 4'd6, 4'd13, 4'd3, 4'd4},
		'{4'd8, 4'd6, 4'd7, 4'd9, 4'd3, 4'd12, 4'd10, 4'd15,
		  4'd13, 4'd1, 4'd14, 4'd4, 4'd0, 4'd11, 4'd5, 4'd2},
		'{4'd0, 4'd15, 4'd11, 4'd8, 4'd12, 4'd9, 4'd6, 4'd3,
		  4'd13, 4'd1, 4'd2, 4'd4, 4'd10, 4'd7, 4'd5, 4'd14},
		'{4'd1, 4'd15, 4'd8, 4'd3, 4'd12, 4'd0, 4'd11, 4'd6,
		  4'd2, 4'd5, 4'd4, 4'd10, 4'd9, 4'd14, 4'd7, 4'd13},
		'{4'd15, 4'd5, 4'd2, 4'd11, 4'd4, 4'd10, 4'd9, 4'd12,
		  4'd0, 4'd3, 4'd14, 4'd8, 4'd13, 4'd6, 4'd7, 4'd1},
		'{4'd7, 4'd2, 4'd12, 4'd5, 4'd8, 4'd4, 4'd6, 4'd11,
		  4'd14, 4'd9, 4'd1, 4'd15, 4'd13, 4'd3, 4'd10, 4'd0},
		'{4'd1, 4'd13, 4'd15, 4'd0, 4'd14, 4'd8, 4'd2, 4'd11,
		  4'd7, 4'd4, 4'd12, 4'd10, 4'd9, 4'd3, 4'd5, 4'd6}
	};

	function automatic word_t rol32(word_t x, int n);
		return (x << n) | (x >> (WORD_W - n));
	endfunction

	function automatic word_t ror32(word_t x, int n);
		return (x >> n) | (x << (WORD_W - n));
	endfunction

	function automatic word_t mirror32(word_t x);
		return {x[7:0], x[15:8], x[23:16], x[31:24]};
	endfunction

	// bitsliced substitution, word 0 holds the nibble LSB
	function automatic blk_t sbox_fwd(logic [2:0] box, blk_t x);
		blk_t y;
		logic [3:0] n;
		logic [3:0] v;
		for (int j = 0; j < WORD_W; j++) begin
			n = {x[3][j], x[2][j], x[1][j], x[0][j]};
			v = SBOX[box][n];
			for (int k = 0; k < 4; k++) begin
				y[k][j] = v[k];
			end
		end
		return y;
	endfunction

	function automatic blk_t sbox_inv(logic [2:0] box, blk_t x);
		blk_t y;
		logic [3:0] n;
		logic [3:0] v;
		for (int j = 0; j < WORD_W; j++) begin
			n = {x[3][j], x[2][j], x[1][j], x[0][j]};
			v = '0;
			for (int i = 0; i < 16; i++) begin
				if (SBOX[box][i] == n) begin
					v = 4'(i);
				end
			end
			for (int k = 0; k < 4; k++) begin
				y[k][j] = v[k];
			end
		end
		return y;
	endfunction

	function automatic blk_t lin_fwd(blk_t x);
		word_t a, b, c, d;
		a = rol32(x[0], 13);
		c = rol32(x[2], 3);
		b = x[1] ^ a ^ c;
		d = x[3] ^ c ^ (a << 3);
		b = rol32(b, 1);
		d = rol32(d, 7);
		a = a ^ b ^ d;
		c = c ^ d ^ (b << 7);
		a = rol32(a, 5);
		c = rol32(c, 22);
		return {d, c, b, a};
	endfunction

	function automatic blk_t lin_inv(blk_t x);
		word_t a, b, c, d;
		a = x[0];
		b = x[1];
		c = ror32(x[2], 22);
		d = x[3];
		a = ror32(a, 5);
		c = c ^ d ^ (b << 7);
		a = a ^ b ^ d;
		d = ror32(d, 7);
		b = ror32(b, 1);
		d = d ^ c ^ (a << 3);
		b = b ^ a ^ c;
		c = ror32(c, 3);
		a = ror32(a, 13);
		return {d, c, b, a};
	endfunction

endpackage

@@ rtl/core/serpent_block_cipher_core.sv @@
// Top level: Serpent-256 encrypt/decrypt core with a 33-stage round pipeline.
//
// Usage:
//   Write the four 64-bit key registers through cfg_we/cfg_idx/cfg_data
//   (index 0..3, word 2i in bits 63:32). Any write to index 0..3 restarts
//   the key schedule (one prekey word per cycle from the recurrence unit);
//   in_ready stays low until it is finished. After reset the schedule
//   runs once on the all-zero key.
//   Blocks enter on in_valid/in_ready with cmd 0 to encrypt, 1 to decrypt.
//   One round per stage after an input key-mixing stage (33 register stages
//   in all); a new transaction can be taken every cycle once the keys are
//   ready and while the pipeline is not stalled.
//   When out_ready is low and the last stage holds a result, the whole
//   pipeline freezes; nothing is dropped or repeated, and in_ready falls.
//   Reset clears all valid bits, the key registers and the key-ready flag.
module serpent_block_cipher_core (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [serp_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [63:0]                    cfg_data,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic                           cmd,
	input  logic [63:0]                    block_hi,
	input  logic [63:0]                    block_lo,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [63:0]                    result_hi,
	output logic [63:0]                    result_lo
);
	import serp_pkg::*;

	blk_t rk [RK_GROUPS];
	logic rk_ready;
	logic adv;
	logic vld [ROUNDS+1];
	logic cmdp [ROUNDS+1];
	blk_t dat [ROUNDS+1];
	blk_t in_blk;
	logic vld_s0;
	logic cmd_s0;
	blk_t dat_s0;

	serp_key_sched u_key (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.rk       (rk),
		.rk_ready (rk_ready)
	);

	// global stall: advance unless the finished result is held
	assign adv      = !vld[ROUNDS] || out_ready;
	assign in_ready = adv && rk_ready;

	assign in_blk = {mirror32(block_lo[31:0]), mirror32(block_lo[63:32]),
		mirror32(block_hi[31:0]), mirror32(block_hi[63:32])};

	// input stage: mirror and initial key mixing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s0 <= 1'b0;
		end else if (adv) begin
			vld_s0 <= in_valid && rk_ready;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cmd_s0 <= cmd;
			dat_s0 <= in_blk ^ ((cmd == CMD_DEC) ? rk[ROUNDS] : rk[0]);
		end
	end

	assign vld[0]  = vld_s0;
	assign cmdp[0] = cmd_s0;
	assign dat[0]  = dat_s0;

	// round stages
	for (genvar s = 0; s < ROUNDS; s++) begin : g_rnd
		serp_round #(.STAGE(s)) u_rnd (
			.clk     (clk),
			.arst_n  (arst_n),
			.adv     (adv),
			.vld_in  (vld[s]),
			.cmd_in  (cmdp[s]),
			.dat_in  (dat[s]),
			.k_enc   (rk[s+1]),
			.k_dec   (rk[ROUNDS-1-s]),
			.vld_out (vld[s+1]),
			.cmd_out (cmdp[s+1]),
			.dat_out (dat[s+1])
		);
	end

	// output mirror
	assign out_valid = vld[ROUNDS];
	assign result_hi = {mirror32(dat[ROUNDS][0]), mirror32(dat[ROUNDS][1])};
	assign result_lo = {mirror32(dat[ROUNDS][2]), mirror32(dat[ROUNDS][3])};

	// a key write always withdraws the round keys
	a_key_wr_clears: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we && cfg_idx < CFG_IDX_W'(KEY_REGS) |=> !rk_ready)
		else $error("round keys still marked ready after key write");

	// a stall freezes the first stage
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> vld[0] == $past(vld[0]))
		else $error("pipeline moved during stall");

	// an accepted transaction appears in the input stage
	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> vld[0])
		else $error("accepted transaction lost at pipeline entry");

endmodule

@@ rtl/core/serp_key_sched.sv @@
// Key registers and sequential round-key expansion, one prekey word per cycle.
module serp_key_sched (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [serp_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [63:0]                    cfg_data,
	output serp_pkg::blk_t                 rk [serp_pkg::RK_GROUPS],
	output logic                           rk_ready
);
	import serp_pkg::*;

	word_t             key_q [KEY_WORDS];
	word_t             win_q [KEY_WORDS];
	blk_t              rk_q  [RK_GROUPS];
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic              done_q;
	logic              key_wr;
	logic              start;
	word_t             nxt;
	logic [RK_IDX_W-1:0] grp;

	assign key_wr = cfg_we && (cfg_idx < CFG_IDX_W'(KEY_REGS));
	assign start  = !key_wr && !done_q && !busy_q;
	assign grp    = cnt_q[CNT_W-1:2];

	// affine prekey recurrence over the 8-word window
	assign nxt = rol32(win_q[0] ^ win_q[3] ^ win_q[5] ^ win_q[7] ^ GOLDEN
		^ WORD_W'(cnt_q), 11);

	// expansion control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (key_wr) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CNT_W'(RK_WORDS - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// key words, zero after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < KEY_WORDS; k++) begin
				key_q[k] <= '0;
			end
		end else if (key_wr) begin
			key_q[{cfg_idx[1:0], 1'b0}] <= cfg_data[63:32];
			key_q[{cfg_idx[1:0], 1'b1}] <= cfg_data[31:0];
		end
	end

	// window and round-key store
	always_ff @(posedge clk) begin
		if (start) begin
			for (int k = 0; k < KEY_WORDS; k++) begin
				win_q[k] <= mirror32(key_q[k]);
			end
		end else if (busy_q) begin
			for (int k = 0; k < KEY_WORDS - 1; k++) begin
				win_q[k] <= win_q[k+1];
			end
			win_q[KEY_WORDS-1] <= nxt;
			if (cnt_q[1:0] == 2'd3) begin
				rk_q[grp] <= sbox_fwd(3'(3'd3 - grp[2:0]),
					{nxt, win_q[7], win_q[6], win_q[5]});
			end
		end
	end

	assign rk       = rk_q;
	assign rk_ready = done_q;

endmodule

@@ rtl/core/serp_round.sv @@
// One pipeline stage: a forward or inverse round, chosen per transaction.
module serp_round #(
	parameter int STAGE = 0
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           adv,
	input  logic           vld_in,
	input  logic           cmd_in,
	input  serp_pkg::blk_t dat_in,
	input  serp_pkg::blk_t k_enc,
	input  serp_pkg::blk_t k_dec,
	output logic           vld_out,
	output logic           cmd_out,
	output serp_pkg::blk_t dat_out
);
	import serp_pkg::*;

	localparam int DEC_RND = ROUNDS - 1 - STAGE;

	blk_t enc_y;
	blk_t dec_y;
	logic vld_s1;
	logic cmd_s1;
	blk_t dat_s1;

	// encrypt: S-box, linear transform (not in the last round), then next round key
	always_comb begin
		enc_y = sbox_fwd(3'(STAGE), dat_in);
		if (STAGE < ROUNDS - 1) begin
			enc_y = lin_fwd(enc_y);
		end
		enc_y = enc_y ^ k_enc;
	end

	// decrypt: inverse transform (not for the last round), inverse S-box, then round key
	always_comb begin
		dec_y = dat_in;
		if (DEC_RND < ROUNDS - 1) begin
			dec_y = lin_inv(dec_y);
		end
		dec_y = sbox_inv(3'(DEC_RND), dec_y) ^ k_dec;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cmd_s1 <= cmd_in;
			dat_s1 <= (cmd_in == CMD_DEC) ? dec_y : enc_y;
		end
	end

	assign vld_out = vld_s1;
	assign cmd_out = cmd_s1;
	assign dat_out = dat_s1;

endmodule

@@ tb/tb_serpent_block_cipher_core.sv @@
// Self-checking testbench for the Serpent-256 cipher core: random blocks under several keys.
module tb_serpent_block_cipher_core;
	timeunit 1ns;
	timeprecision 1ps;
	import serp_pkg::*;

	typedef struct {
		logic        dir;
		logic [63:0] hi;
		logic [63:0] lo;
	} block_item_t;

	typedef struct {
		logic [63:0] hi;
		logic [63:0] lo;
	} cipher_out_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_idx = '0;
	logic [63:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic        cmd = CMD_ENC;
	logic [63:0] block_hi = '0;
	logic [63:0] block_lo = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [63:0] result_hi;
	logic [63:0] result_lo;

	block_item_t pend_q[$];
	cipher_out_t cipher_q[$];
	logic        took = 1'b0;
	logic        calm = 1'b1;
	int          errors = 0;

	// key registers and expanded schedule of the model
	word_t key_word [KEY_WORDS];
	word_t sched [RK_WORDS];

	serpent_block_cipher_core u_dut (.*);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic word_t rotl(word_t w, int n);
		return (w << n) | (w >> (32 - n));
	endfunction

	function automatic word_t swap_bytes(word_t w);
		return {w[7:0], w[15:8], w[23:16], w[31:24]};
	endfunction

	// bitsliced S-box pass, inverse table built on the fly
	function automatic blk_t subst(int box, logic inv_dir, blk_t x);
		blk_t y;
		logic [3:0] tbl [16];
		logic [3:0] v;
		for (int i = 0; i < 16; i++) begin
			if (inv_dir) tbl[SBOX[box][i]] = 4'(i);
			else tbl[i] = SBOX[box][i];
		end
		for (int j = 0; j < 32; j++) begin
			v = tbl[{x[3][j], x[2][j], x[1][j], x[0][j]}];
			for (int k = 0; k < 4; k++) y[k][j] = v[k];
		end
		return y;
	endfunction

	function automatic blk_t mix_fwd(blk_t x);
		word_t a, b, c, d;
		a = rotl(x[0], 13);
		c = rotl(x[2], 3);
		b = x[1] ^ a ^ c;
		d = x[3] ^ c ^ (a << 3);
		b = rotl(b, 1);
		d = rotl(d, 7);
		a = a ^ b ^ d;
		c = c ^ d ^ (b << 7);
		return {d, rotl(c, 22), b, rotl(a, 5)};
	endfunction

	function automatic blk_t mix_back(blk_t x);
		word_t a, b, c, d;
		c = rotl(x[2], 10);
		a = rotl(x[0], 27);
		b = x[1];
		d = x[3];
		c = c ^ d ^ (b << 7);
		a = a ^ b ^ d;
		d = rotl(d, 25);
		b = rotl(b, 31);
		d = d ^ c ^ (a << 3);
		b = b ^ a ^ c;
		return {d, rotl(c, 29), b, rotl(a, 19)};
	endfunction

	// prekey recurrence then S-box passes over each group of four
	function automatic void build_schedule();
		word_t w [KEY_WORDS + RK_WORDS];
		blk_t g;
		for (int i = 0; i < KEY_WORDS; i++) w[i] = swap_bytes(key_word[i]);
		for (int i = 0; i < RK_WORDS; i++)
			w[i + 8] = rotl(w[i] ^ w[i + 3] ^ w[i + 5] ^ w[i + 7] ^ GOLDEN ^ word_t'(i), 11);
		for (int r = 0; r < RK_GROUPS; r++) begin
			g = {w[8 + 4*r + 3], w[8 + 4*r + 2], w[8 + 4*r + 1], w[8 + 4*r]};
			g = subst((11 - r) & 7, 1'b0, g);
			for (int k = 0; k < 4; k++) sched[4*r + k] = g[k];
		end
	endfunction

	function automatic blk_t add_key(blk_t x, int r);
		for (int k = 0; k < 4; k++) x[k] ^= sched[4*r + k];
		return x;
	endfunction

	function automatic cipher_out_t cipher_block(block_item_t it);
		blk_t x;
		cipher_out_t o;
		x = {swap_bytes(it.lo[31:0]), swap_bytes(it.lo[63:32]),
		     swap_bytes(it.hi[31:0]), swap_bytes(it.hi[63:32])};
		if (it.dir == CMD_ENC) begin
			for (int r = 0; r < ROUNDS; r++) begin
				x = subst(r & 7, 1'b0, add_key(x, r));
				if (r < ROUNDS - 1) x = mix_fwd(x);
			end
			x = add_key(x, ROUNDS);
		end else begin
			x = add_key(x, ROUNDS);
			for (int r = ROUNDS - 1; r >= 0; r--) begin
				if (r < ROUNDS - 1) x = mix_back(x);
				x = add_key(subst(r & 7, 1'b1, x), r);
			end
		end
		o.hi = {swap_bytes(x[0]), swap_bytes(x[1])};
		o.lo = {swap_bytes(x[2]), swap_bytes(x[3])};
		return o;
	endfunction

	// sender: new transaction at falling edge, valid held until taken
	always @(negedge clk) begin
		if (arst_n && (!in_valid || took)) begin
			if (pend_q.size() > 0 && (calm || $urandom_range(99) >= 6)) begin
				in_valid <= 1'b1;
				cmd      <= pend_q[0].dir;
				block_hi <= pend_q[0].hi;
				block_lo <= pend_q[0].lo;
				void'(pend_q.pop_front());
			end else begin
				in_valid <= 1'b0;
			end
		end
		out_ready <= calm || ($urandom_range(99) >= 6);
	end

	// acceptance and result check at rising edge
	always @(posedge clk) begin
		block_item_t it;
		cipher_out_t e;
		took <= in_valid && in_ready;
		if (in_valid && in_ready) begin
			it.dir = cmd;
			it.hi  = block_hi;
			it.lo  = block_lo;
			cipher_q.push_back(cipher_block(it));
		end
		if (out_valid && out_ready) begin
			if (cipher_q.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected result %h %h", result_hi, result_lo);
			end else begin
				e = cipher_q.pop_front();
				if (e.hi !== result_hi || e.lo !== result_lo) begin
					errors++;
					if (errors <= 10)
						$display("mismatch: exp %h %h got %h %h", e.hi, e.lo, result_hi, result_lo);
				end
			end
		end
	end

	task automatic write_key(int idx, logic [63:0] val);
		@(negedge clk);
		cfg_we   = 1'b1;
		cfg_idx  = CFG_IDX_W'(idx);
		cfg_data = val;
		@(negedge clk);
		cfg_we = 1'b0;
		if (idx < KEY_REGS) begin
			key_word[2*idx]     = val[63:32];
			key_word[2*idx + 1] = val[31:0];
			build_schedule();
		end
	endtask

	task automatic queue_block(logic d, logic [63:0] h, logic [63:0] l);
		block_item_t it;
		it.dir = d;
		it.hi  = h;
		it.lo  = l;
		pend_q.push_back(it);
	endtask

	task automatic queue_random(int n);
		logic [63:0] h, l;
		for (int i = 0; i < n; i++) begin
			h = {$urandom, $urandom};
			l = {$urandom, $urandom};
			if ($urandom_range(19) == 0) h = $urandom_range(1) ? '1 : '0;
			if ($urandom_range(19) == 0) l = $urandom_range(1) ? '1 : '0;
			queue_block(1'($urandom_range(1)), h, l);
		end
	endtask

	// wait until drained, then let the pipeline settle
	task automatic drain();
		while (pend_q.size() > 0 || in_valid || cipher_q.size() > 0) @(negedge clk);
		repeat (40) @(negedge clk);
	endtask

	logic [63:0] pats [4] = '{64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0001,
	                          64'h0123_4567_89AB_CDEF};

	initial begin
		for (int i = 0; i < KEY_WORDS; i++) key_word[i] = '0;
		build_schedule();
		repeat (7) @(negedge clk);
		arst_n = 1'b1;

		// all-zero key after reset, extremes of the block, no idling
		foreach (pats[i]) begin
			queue_block(CMD_ENC, pats[i], pats[3 - i]);
			queue_block(CMD_DEC, pats[i], pats[3 - i]);
			queue_block(CMD_ENC, pats[i], pats[i]);
			queue_block(CMD_DEC, pats[i], pats[i]);
		end
		drain();
		calm = 1'b0;

		// all-ones key
		for (int i = 0; i < KEY_REGS; i++) write_key(i, '1);
		queue_random(80);
		drain();

		// random key, out-of-range writes ignored
		for (int i = 0; i < KEY_REGS; i++) write_key(i, {$urandom, $urandom});
		for (int i = KEY_REGS; i < 8; i++) write_key(i, {$urandom, $urandom});
		queue_random(80);
		drain();

		// single register change forces re-expansion
		write_key(1, {$urandom, $urandom});
		queue_random(80);
		drain();

		// zero key via writes, then alternating patterns
		for (int i = 0; i < KEY_REGS; i++) write_key(i, '0);
		queue_random(40);
		drain();
		for (int i = 0; i < KEY_REGS; i++) write_key(i, (i & 1) ? 64'h5A5A_5A5A_A5A5_A5A5 : 64'hA5A5_A5A5_5A5A_5A5A);
		queue_random(40);
		drain();

		for (int i = 0; i < KEY_REGS; i++) write_key(i, {$urandom, $urandom});
		queue_random(80);
		drain();

		if (errors == 0) $display("Testbench completed without errors");
		else $display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		#4ms;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
